/* rtl/ceij_pkg.sv */
// ----------------------------------------------------------------------------
// ceij_pkg
// shared types and constants for the cubic edge invertibility check
// ----------------------------------------------------------------------------
package ceij_pkg;

  localparam int CEIJ_COORD_BITS = 24;
  localparam int CEIJ_TOL_BITS   = 24;
  localparam int CEIJ_LIMB       = 32;

  // decision codes
  localparam logic [2:0] CASE_DEGENERATE = 3'd0;
  localparam logic [2:0] CASE_CONSTANT   = 3'd1;
  localparam logic [2:0] CASE_LINEAR     = 3'd2;
  localparam logic [2:0] CASE_NO_ROOTS   = 3'd3;
  localparam logic [2:0] CASE_ROOTS      = 3'd4;

  typedef struct packed {
    logic signed [CEIJ_COORD_BITS-1:0] end0_x;
    logic signed [CEIJ_COORD_BITS-1:0] end0_y;
    logic signed [CEIJ_COORD_BITS-1:0] end0_z;
    logic signed [CEIJ_COORD_BITS-1:0] end1_x;
    logic signed [CEIJ_COORD_BITS-1:0] end1_y;
    logic signed [CEIJ_COORD_BITS-1:0] end1_z;
    logic signed [CEIJ_COORD_BITS-1:0] inner_a_x;
    logic signed [CEIJ_COORD_BITS-1:0] inner_a_y;
    logic signed [CEIJ_COORD_BITS-1:0] inner_a_z;
    logic signed [CEIJ_COORD_BITS-1:0] inner_b_x;
    logic signed [CEIJ_COORD_BITS-1:0] inner_b_y;
    logic signed [CEIJ_COORD_BITS-1:0] inner_b_z;
  } edge_in_t;

  typedef struct packed {
    logic       invertible;
    logic [2:0] decision_case;
  } edge_out_t;

endpackage

/* rtl/ceij_mul.sv */
// ----------------------------------------------------------------------------
// ceij_mul
// four-stage signed multiplier built from 32x32 limb products
// ----------------------------------------------------------------------------
module ceij_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  import ceij_pkg::*;

  localparam int LA = (AW + CEIJ_LIMB - 1) / CEIJ_LIMB;
  localparam int LB = (BW + CEIJ_LIMB - 1) / CEIJ_LIMB;
  localparam int SW = (LA + LB) * CEIJ_LIMB;

  logic [AW-1:0]           a_abs;
  logic [BW-1:0]           b_abs;
  logic [LA*CEIJ_LIMB-1:0] ma;
  logic [LB*CEIJ_LIMB-1:0] mb;
  logic [2*CEIJ_LIMB-1:0]  pp [LA][LB];
  logic [SW-1:0]           acc;
  logic [AW+BW-1:0]        mag;
  logic                    neg1, neg2, neg3;

  assign a_abs = a[AW-1] ? (~a + 1'b1) : a;
  assign b_abs = b[BW-1] ? (~b + 1'b1) : b;

  always_comb begin
    acc = '0;
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        acc = acc + (SW'(pp[i][j]) << ((i + j) * CEIJ_LIMB));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= (LA*CEIJ_LIMB)'(a_abs);
      mb   <= (LB*CEIJ_LIMB)'(b_abs);
      neg1 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          pp[i][j] <= ma[i*CEIJ_LIMB +: CEIJ_LIMB] * mb[j*CEIJ_LIMB +: CEIJ_LIMB];
        end
      end
      neg2 <= neg1;
      mag  <= acc[AW+BW-1:0];
      neg3 <= neg2;
      p    <= neg3 ? $signed(~mag + 1'b1) : $signed(mag);
    end
  end

endmodule

/* rtl/cubic_edge_invertibility_check.sv */
// ----------------------------------------------------------------------------
// cubic_edge_invertibility_check
// exact integer sign test of the tangential jacobian of a cubic edge
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  in       | in_valid / in_ready    | in_data   (edge_in_t)
//  out      | out_valid / out_ready  | out_data  (edge_out_t)
//  config   | cfg_we                 | cfg_wdata (tolerance)
//
// one item per cycle while the output is not stalled, thirteen register stages;
// the depth includes two four-stage limb multipliers in series
// rst clears the stage valid bits and the tolerance register
// a stalled output freezes every stage together, nothing is lost or repeated
// ----------------------------------------------------------------------------
module cubic_edge_invertibility_check #(
  parameter int COORD_BITS = ceij_pkg::CEIJ_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ceij_pkg::edge_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ceij_pkg::edge_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ceij_pkg::CEIJ_TOL_BITS-1:0]  cfg_wdata
);
  import ceij_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int VW  = CB + 8;            // A, B, C components
  localparam int PW  = 2 * VW + 2;        // P, Q, R
  localparam int TW  = CEIJ_TOL_BITS + 4; // T = 16 * tolerance
  localparam int TTW = 2 * TW;
  localparam int RW  = TTW + 1 + PW;      // T^2 R
  localparam int CW  = ((2 * PW > RW) ? 2 * PW : RW) + 3;
  localparam int NST = 13;

  logic [CEIJ_TOL_BITS-1:0] tol;
  logic [NST:1]             vld;
  logic                     en;

  // whole pipe advances unless the result register is held
  assign en        = !vld[NST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      if (en) begin
        vld <= {vld[NST-1:1], in_valid};
      end
    end
  end

  // stage 1: capture nodes, x[node][dim]
  logic signed [CB-1:0] x [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      x[0][0] <= CB'(in_data.end0_x);
      x[0][1] <= CB'(in_data.end0_y);
      x[0][2] <= CB'(in_data.end0_z);
      x[1][0] <= CB'(in_data.end1_x);
      x[1][1] <= CB'(in_data.end1_y);
      x[1][2] <= CB'(in_data.end1_z);
      x[2][0] <= CB'(in_data.inner_a_x);
      x[2][1] <= CB'(in_data.inner_a_y);
      x[2][2] <= CB'(in_data.inner_a_z);
      x[3][0] <= CB'(in_data.inner_b_x);
      x[3][1] <= CB'(in_data.inner_b_y);
      x[3][2] <= CB'(in_data.inner_b_z);
    end
  end

  // stage 2: sixteenfold derivative coefficients per dimension
  logic signed [VW-1:0] av [3];
  logic signed [VW-1:0] bv [3];
  logic signed [VW-1:0] cv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 3; d++) begin
        av[d] <= VW'(27) * (VW'(x[1][d]) - VW'(x[0][d])
                 + VW'(3) * (VW'(x[2][d]) - VW'(x[3][d])));
        bv[d] <= VW'(18) * (VW'(x[0][d]) + VW'(x[1][d])
                 - VW'(x[2][d]) - VW'(x[3][d]));
        cv[d] <= VW'(x[0][d]) - VW'(x[1][d])
                 + VW'(27) * (VW'(x[3][d]) - VW'(x[2][d]));
      end
    end
  end

  // stages 3-6: dot product terms
  logic signed [2*VW-1:0] ac [3];
  logic signed [2*VW-1:0] bc [3];
  logic signed [2*VW-1:0] cc [3];

  for (genvar d = 0; d < 3; d++) begin : g_dot
    ceij_mul #(.AW(VW), .BW(VW)) u_ac (.clk, .en, .a(av[d]), .b(cv[d]), .p(ac[d]));
    ceij_mul #(.AW(VW), .BW(VW)) u_bc (.clk, .en, .a(bv[d]), .b(cv[d]), .p(bc[d]));
    ceij_mul #(.AW(VW), .BW(VW)) u_cc (.clk, .en, .a(cv[d]), .b(cv[d]), .p(cc[d]));
  end

  // stage 7: P, Q, R and T^2 (the user must keep to: tolerance only changes while idle; the block does not enforce it)
  logic signed [PW-1:0] p7, q7, r7;
  logic [TW-1:0]        t_full;
  logic signed [TTW:0]  tt7;

  assign t_full = {tol, 4'b0000};

  always_ff @(posedge clk) begin
    if (en) begin
      p7  <= PW'(ac[0]) + PW'(ac[1]) + PW'(ac[2]);
      q7  <= PW'(bc[0]) + PW'(bc[1]) + PW'(bc[2]);
      r7  <= PW'(cc[0]) + PW'(cc[1]) + PW'(cc[2]);
      // full-width square, the concatenation would otherwise keep only TW bits
      tt7 <= $signed({1'b0, TTW'(t_full) * TTW'(t_full)});
    end
  end

  // stages 8-11: squares and cross products
  logic signed [2*PW-1:0] pp11, qq11, pr11;
  logic signed [RW-1:0]   ttr11;

  ceij_mul #(.AW(PW), .BW(PW))    u_pp  (.clk, .en, .a(p7),  .b(p7), .p(pp11));
  ceij_mul #(.AW(PW), .BW(PW))    u_qq  (.clk, .en, .a(q7),  .b(q7), .p(qq11));
  ceij_mul #(.AW(PW), .BW(PW))    u_pr  (.clk, .en, .a(p7),  .b(r7), .p(pr11));
  ceij_mul #(.AW(TTW+1), .BW(PW)) u_ttr (.clk, .en, .a(tt7), .b(r7), .p(ttr11));

  // P, Q, R, T^2 ride alongside the multipliers
  logic signed [PW-1:0] pd [4];
  logic signed [PW-1:0] qd [4];
  logic signed [PW-1:0] rd [4];
  logic signed [TTW:0]  td [4];

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= p7;
      qd[0] <= q7;
      rd[0] <= r7;
      td[0] <= tt7;
      for (int k = 1; k < 4; k++) begin
        pd[k] <= pd[k-1];
        qd[k] <= qd[k-1];
        rd[k] <= rd[k-1];
        td[k] <= td[k-1];
      end
    end
  end

  // stage 12: sign tests, all in one common width
  logic signed [CW-1:0] cp, cq, cr, cabsq;
  logic degen, p_small, q_small, disc_neg, f1_le, fm1_le, p_pos, q_le_2p, q_lt_r;

  assign cp    = CW'(pd[3]);
  assign cq    = CW'(qd[3]);
  assign cr    = CW'(rd[3]);
  assign cabsq = cq[CW-1] ? -cq : cq;

  always_ff @(posedge clk) begin
    if (en) begin
      degen    <= cr <= CW'(td[3]);
      p_small  <= CW'(pp11) <= CW'(ttr11);
      q_small  <= CW'(qq11) <= CW'(ttr11);
      disc_neg <= (CW'(qq11) - (CW'(pr11) <<< 2)) < 0;
      f1_le    <= (cp + cq + cr) <= 0;
      fm1_le   <= (cp - cq + cr) <= 0;
      p_pos    <= cp > 0;
      q_le_2p  <= cabsq <= (cp <<< 1);
      q_lt_r   <= cabsq < cr;
    end
  end

  // stage 13: decision, held here under a stall
  always_ff @(posedge clk) begin
    if (en) begin
      if (degen) begin
        out_data.invertible    <= 1'b0;
        out_data.decision_case <= CASE_DEGENERATE;
      end else if (p_small && q_small) begin
        out_data.invertible    <= 1'b1;
        out_data.decision_case <= CASE_CONSTANT;
      end else if (p_small) begin
        out_data.invertible    <= q_lt_r;
        out_data.decision_case <= CASE_LINEAR;
      end else if (disc_neg) begin
        out_data.invertible    <= 1'b1;
        out_data.decision_case <= CASE_NO_ROOTS;
      end else begin
        // root in [-1,1] if an endpoint is non-positive or the vertex lies inside
        out_data.invertible    <= !(f1_le || fm1_le || (p_pos && q_le_2p));
        out_data.decision_case <= CASE_ROOTS;
      end
    end
  end

endmodule
